// ----- hdl/differential_drive_odometry_defines.svh -----
// ----------------------------------------------------------------------------
// Differential drive odometry assertion macros
// Concurrent check wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`ifndef SYNTHESIS
`define DDO_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("odometry check failed");
`define DDO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("odometry check failed");
`else
`define DDO_ASSERT_IMPL(label, ante, cons)
`define DDO_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/ddo_pkg.sv -----
// ----------------------------------------------------------------------------
// Differential drive odometry package
// Widths, constants, shared types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int POS_W      = 48;
    localparam int OUT_POS_W  = 48;
    localparam int DIST_W     = 32;
    localparam int TIME_W     = 24;
    localparam int TRACK_W    = 24;
    localparam int HEAD_W     = 32;
    localparam int VEL_W      = 32;
    localparam int PX_W       = 36;
    localparam int SUM_W      = ((POS_W > OUT_POS_W) ? POS_W : OUT_POS_W) + 1;
    localparam int NUM_W      = 62;
    localparam int DSH_W      = TIME_W + VEL_W - 1;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;

    localparam int CORDIC_STEPS = 30;
    localparam int CNT_W        = 5;
    localparam int CORDIC_W     = 34;

    localparam logic [TRACK_W-1:0] TRACK_RESET = 24'd374491;
    localparam logic [29:0] RAD_TO_BAU = 30'd683565276;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [CORDIC_W-1:0] HALF_TURN = 34'sd2147483648;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    typedef struct packed {
        logic signed [DIST_W-1:0] dl;
        logic signed [DIST_W-1:0] dr;
        logic [TIME_W-1:0]        dt;
    } t_delta;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_status;

    function automatic logic signed [CORDIC_W-1:0] atan_bau(input logic [CNT_W-1:0] idx);
        case (idx)
            5'd0:    return 34'sd536870912;
            5'd1:    return 34'sd316933406;
            5'd2:    return 34'sd167458907;
            5'd3:    return 34'sd85004756;
            5'd4:    return 34'sd42667331;
            5'd5:    return 34'sd21354465;
            5'd6:    return 34'sd10679838;
            5'd7:    return 34'sd5340245;
            5'd8:    return 34'sd2670163;
            5'd9:    return 34'sd1335087;
            5'd10:   return 34'sd667544;
            5'd11:   return 34'sd333772;
            5'd12:   return 34'sd166886;
            5'd13:   return 34'sd83443;
            5'd14:   return 34'sd41722;
            5'd15:   return 34'sd20861;
            5'd16:   return 34'sd10430;
            5'd17:   return 34'sd5215;
            5'd18:   return 34'sd2608;
            5'd19:   return 34'sd1304;
            5'd20:   return 34'sd652;
            5'd21:   return 34'sd326;
            5'd22:   return 34'sd163;
            5'd23:   return 34'sd81;
            5'd24:   return 34'sd41;
            5'd25:   return 34'sd20;
            5'd26:   return 34'sd10;
            5'd27:   return 34'sd5;
            5'd28:   return 34'sd3;
            5'd29:   return 34'sd1;
            default: return 34'sd0;
        endcase
    endfunction

endpackage

// ----- hdl/differential_drive_odometry.sv -----
// ----------------------------------------------------------------------------
// Differential drive odometry
// Wheel odometry: pose and velocities from cumulative wheel distances.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries left and right cumulative distance
// (Q16 m) and elapsed time (us). Output channel o_valid/i_ready carries x, y,
// heading (binary angle), linear and angular velocity and velocity_valid.
// One result per sample. The back end works on one sample at a time, with a
// 30-step CORDIC running beside two 32-step radix-2 velocity dividers,
// which are skipped for a zero elapsed time. A two-entry queue decouples
// the front end, so input transfers continue while a sample is being
// worked on; the output register lets the back end start the next sample
// while a result waits. If the receiver stalls, the result is held and the
// back end stops at its final step; the queue then fills and o_ready falls.
// i_cfg_we writes the inverse track width; write only when idle. Reset
// clears pose, heading and the first-sample flag and restores the default
// track width; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_defines.svh"

module differential_drive_odometry (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [ddo_pkg::DIST_W-1:0]    i_left_distance,
    input  logic signed [ddo_pkg::DIST_W-1:0]    i_right_distance,
    input  logic        [ddo_pkg::TIME_W-1:0]    i_elapsed_time,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [ddo_pkg::OUT_POS_W-1:0] o_x_position,
    output logic signed [ddo_pkg::OUT_POS_W-1:0] o_y_position,
    output logic        [ddo_pkg::HEAD_W-1:0]    o_heading,
    output logic signed [ddo_pkg::VEL_W-1:0]     o_linear_velocity,
    output logic signed [ddo_pkg::VEL_W-1:0]     o_angular_velocity,
    output logic                                 o_velocity_valid,
    input  logic                                 i_cfg_we,
    input  logic        [ddo_pkg::TRACK_W-1:0]   i_cfg_data
);
    import ddo_pkg::*;

    logic [TRACK_W-1:0] r_track;
    logic               w_push;
    logic               w_pop;
    t_delta             w_push_data;
    t_delta             w_pop_data;
    t_fifo_status       w_fifo_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= TRACK_RESET;
        end else if (i_cfg_we) begin
            r_track <= i_cfg_data;
        end
    end

    ddo_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_left_distance  (i_left_distance),
        .i_right_distance (i_right_distance),
        .i_elapsed_time   (i_elapsed_time),
        .i_fifo_status    (w_fifo_status),
        .o_push           (w_push),
        .o_push_data      (w_push_data)
    );

    ddo_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_status    (w_fifo_status)
    );

    ddo_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_track            (r_track),
        .i_fifo_status      (w_fifo_status),
        .i_pop_data         (w_pop_data),
        .o_pop              (w_pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_x_position       (o_x_position),
        .o_y_position       (o_y_position),
        .o_heading          (o_heading),
        .o_linear_velocity  (o_linear_velocity),
        .o_angular_velocity (o_angular_velocity),
        .o_velocity_valid   (o_velocity_valid)
    );

    `DDO_ASSERT_NEXT(a_push_fills_queue, w_push, !w_fifo_status.empty)
    `DDO_ASSERT_IMPL(a_no_velocity_zero, o_valid && !o_velocity_valid,
        o_linear_velocity == '0 && o_angular_velocity == '0)
    `DDO_ASSERT_IMPL(a_pop_needs_data, w_pop, !w_fifo_status.empty)

endmodule

// ----- hdl/ddo_front.sv -----
// ----------------------------------------------------------------------------
// Odometry front end
// Accepts wheel samples and turns cumulative distances into deltas.
// ----------------------------------------------------------------------------
module ddo_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [ddo_pkg::DIST_W-1:0]  i_left_distance,
    input  logic signed [ddo_pkg::DIST_W-1:0]  i_right_distance,
    input  logic        [ddo_pkg::TIME_W-1:0]  i_elapsed_time,
    input  ddo_pkg::t_fifo_status              i_fifo_status,
    output logic                               o_push,
    output ddo_pkg::t_delta                    o_push_data
);
    import ddo_pkg::*;

    logic              r_started;
    logic [DIST_W-1:0] r_left_prev;
    logic [DIST_W-1:0] r_right_prev;

    assign o_ready = !i_fifo_status.full;
    assign o_push  = i_valid && o_ready;

    // first sample is the zero point: deltas forced to zero
    always_comb begin
        o_push_data.dt = i_elapsed_time;
        if (r_started) begin
            o_push_data.dl = $signed(i_left_distance - r_left_prev);
            o_push_data.dr = $signed(i_right_distance - r_right_prev);
        end else begin
            o_push_data.dl = '0;
            o_push_data.dr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else if (o_push) begin
            r_started <= 1'b1;
        end
        if (o_push) begin
            r_left_prev  <= i_left_distance;
            r_right_prev <= i_right_distance;
        end
    end

endmodule

// ----- hdl/ddo_fifo.sv -----
// ----------------------------------------------------------------------------
// Odometry delta queue
// Short register queue between front end and back end.
// ----------------------------------------------------------------------------
module ddo_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ddo_pkg::t_delta       i_push_data,
    input  logic                  i_pop,
    output ddo_pkg::t_delta       o_pop_data,
    output ddo_pkg::t_fifo_status o_status
);
    import ddo_pkg::*;

    t_delta             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_pop_data      = r_mem[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == FIFO_DEPTH[FIFO_AW:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- hdl/ddo_div.sv -----
// ----------------------------------------------------------------------------
// Odometry velocity divider
// Radix-2 restoring divide by elapsed time, truncating, saturated to 32 bits.
// ----------------------------------------------------------------------------
module ddo_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ddo_pkg::NUM_W-1:0]  i_num,
    input  logic        [ddo_pkg::TIME_W-1:0] i_den,
    output logic                              o_busy,
    output logic signed [ddo_pkg::VEL_W-1:0]  o_quot
);
    import ddo_pkg::*;

    logic              r_busy;
    logic              r_neg;
    logic              r_ovf;
    logic [NUM_W-1:0]  r_rem;
    logic [DSH_W-1:0]  r_den_sh;
    logic [VEL_W-1:0]  r_quot;
    logic [CNT_W-1:0]  r_cnt;

    logic [NUM_W-1:0]  w_mag;
    logic [NUM_W-1:0]  w_den_full;
    logic [NUM_W-1:0]  w_den_step;
    logic              w_fit;

    assign w_mag      = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_den_full = {{(NUM_W-TIME_W-VEL_W){1'b0}}, i_den, {VEL_W{1'b0}}};
    assign w_den_step = {{(NUM_W-DSH_W){1'b0}}, r_den_sh};
    assign w_fit      = (r_rem >= w_den_step);
    assign o_busy     = r_busy;

    always_comb begin
        if (r_neg) begin
            if (r_ovf || r_quot > {1'b1, {(VEL_W-1){1'b0}}}) begin
                o_quot = {1'b1, {(VEL_W-1){1'b0}}};
            end else begin
                o_quot = $signed(-r_quot);
            end
        end else begin
            if (r_ovf || r_quot[VEL_W-1]) begin
                o_quot = {1'b0, {(VEL_W-1){1'b1}}};
            end else begin
                o_quot = $signed(r_quot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
        if (i_start) begin
            r_neg    <= i_num[NUM_W-1];
            r_ovf    <= (w_mag >= w_den_full);
            r_rem    <= w_mag;
            r_den_sh <= {i_den, {(VEL_W-1){1'b0}}};
            r_quot   <= '0;
            r_cnt    <= CNT_W'(VEL_W - 1);
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - w_den_step;
            end
            r_quot   <= {r_quot[VEL_W-2:0], w_fit};
            r_den_sh <= r_den_sh >> 1;
            r_cnt    <= r_cnt - 1'b1;
        end
    end

endmodule

// ----- hdl/ddo_back.sv -----
// ----------------------------------------------------------------------------
// Odometry back end
// Heading, CORDIC position update, velocities and the result register.
// ----------------------------------------------------------------------------
module ddo_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic        [ddo_pkg::TRACK_W-1:0]   i_track,
    input  ddo_pkg::t_fifo_status                i_fifo_status,
    input  ddo_pkg::t_delta                      i_pop_data,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [ddo_pkg::OUT_POS_W-1:0] o_x_position,
    output logic signed [ddo_pkg::OUT_POS_W-1:0] o_y_position,
    output logic        [ddo_pkg::HEAD_W-1:0]    o_heading,
    output logic signed [ddo_pkg::VEL_W-1:0]     o_linear_velocity,
    output logic signed [ddo_pkg::VEL_W-1:0]     o_angular_velocity,
    output logic                                 o_velocity_valid
);
    import ddo_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_HEAD  = 13'b0000000000010,
        S_K0    = 13'b0000000000100,
        S_K1    = 13'b0000000001000,
        S_VL    = 13'b0000000010000,
        S_VA    = 13'b0000000100000,
        S_START = 13'b0000001000000,
        S_CINIT = 13'b0000010000000,
        S_RUN   = 13'b0000100000000,
        S_MX    = 13'b0001000000000,
        S_MY    = 13'b0010000000000,
        S_UPD   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    localparam logic signed [SUM_W-1:0] POS_HI =
        {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_LO =
        {{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

    t_state                     r_state;
    logic signed [DIST_W-1:0]   r_dl;
    logic signed [DIST_W-1:0]   r_dr;
    logic [TIME_W-1:0]          r_dt;
    logic signed [DIST_W-1:0]   r_mean;
    logic signed [56:0]         r_prodw;
    logic [53:0]                r_p0;
    logic [24:0]                r_p1;
    logic signed [51:0]         r_lin_num;
    logic signed [60:0]         r_ang_num;
    logic [HEAD_W-1:0]          r_dbau;
    logic [HEAD_W-1:0]          r_half;
    logic signed [CORDIC_W-1:0] r_cx;
    logic signed [CORDIC_W-1:0] r_cy;
    logic signed [CORDIC_W-1:0] r_cz;
    logic                       r_flip;
    logic [CNT_W-1:0]           r_cnt;
    logic signed [PX_W-1:0]     r_px;
    logic signed [PX_W-1:0]     r_py;
    logic signed [POS_W-1:0]    r_x_acc;
    logic signed [POS_W-1:0]    r_y_acc;
    logic [HEAD_W-1:0]          r_heading;
    logic                       r_out_valid;

    logic signed [32:0]          w_sum;
    logic signed [32:0]          w_diff;
    logic signed [57:0]          w_prodw;
    logic signed [40:0]          w_a;
    logic [48:0]                 w_a49;
    logic [49:0]                 w_p1_full;
    logic signed [52:0]          w_lin_full;
    logic signed [61:0]          w_ang_full;
    logic [48:0]                 w_kprod;
    logic [HEAD_W-1:0]           w_angle;
    logic signed [CORDIC_W-1:0]  w_z0;
    logic signed [CORDIC_W-1:0]  w_xs;
    logic signed [CORDIC_W-1:0]  w_ys;
    logic signed [CORDIC_W-1:0]  w_cos;
    logic signed [CORDIC_W-1:0]  w_sin;
    logic signed [65:0]          w_mx;
    logic signed [65:0]          w_my;
    logic signed [SUM_W-1:0]     w_x_sum;
    logic signed [SUM_W-1:0]     w_y_sum;
    logic signed [SUM_W-1:0]     w_x_ext;
    logic signed [SUM_W-1:0]     w_y_ext;
    logic                        w_load;
    logic                        w_div_start;
    logic                        w_lin_busy;
    logic                        w_ang_busy;
    logic signed [VEL_W-1:0]     w_lin_q;
    logic signed [VEL_W-1:0]     w_ang_q;

    assign w_sum      = {r_dl[DIST_W-1], r_dl} + {r_dr[DIST_W-1], r_dr};
    assign w_diff     = {r_dr[DIST_W-1], r_dr} - {r_dl[DIST_W-1], r_dl};
    assign w_prodw    = w_diff * $signed({1'b0, i_track});
    assign w_a        = r_prodw[56:16];
    assign w_a49      = {{8{w_a[40]}}, w_a};
    assign w_p1_full  = w_a49[48:24] * RAD_TO_BAU[24:0];
    assign w_lin_full = r_mean * $signed({1'b0, USEC_PER_SEC});
    assign w_ang_full = w_a * $signed({1'b0, USEC_PER_SEC});
    assign w_kprod    = r_p0[48:0] + {r_p1, 24'b0};
    assign w_angle    = r_heading + r_half;
    assign w_z0       = $signed({{(CORDIC_W-HEAD_W){w_angle[HEAD_W-1]}}, w_angle});
    assign w_xs       = r_cx >>> r_cnt;
    assign w_ys       = r_cy >>> r_cnt;
    assign w_cos      = r_flip ? -r_cx : r_cx;
    assign w_sin      = r_flip ? -r_cy : r_cy;
    assign w_mx       = r_mean * w_cos;
    assign w_my       = r_mean * w_sin;
    assign w_x_sum    = {{(SUM_W-POS_W){r_x_acc[POS_W-1]}}, r_x_acc}
                      + {{(SUM_W-PX_W){r_px[PX_W-1]}}, r_px};
    assign w_y_sum    = {{(SUM_W-POS_W){r_y_acc[POS_W-1]}}, r_y_acc}
                      + {{(SUM_W-PX_W){r_py[PX_W-1]}}, r_py};
    assign w_x_ext    = {{(SUM_W-POS_W){r_x_acc[POS_W-1]}}, r_x_acc};
    assign w_y_ext    = {{(SUM_W-POS_W){r_y_acc[POS_W-1]}}, r_y_acc};
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign w_div_start = (r_state == S_CINIT) && (r_dt != '0);

    assign o_pop   = (r_state == S_IDLE) && !i_fifo_status.empty;
    assign o_valid = r_out_valid;

    ddo_div u_div_lin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (NUM_W'(r_lin_num)),
        .i_den   (r_dt),
        .o_busy  (w_lin_busy),
        .o_quot  (w_lin_q)
    );

    ddo_div u_div_ang (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (NUM_W'(r_ang_num)),
        .i_den   (r_dt),
        .o_busy  (w_ang_busy),
        .o_quot  (w_ang_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_x_acc     <= '0;
            r_y_acc     <= '0;
            r_heading   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD:  r_state <= S_K0;
                S_K0:    r_state <= S_K1;
                S_K1:    r_state <= S_VL;
                S_VL:    r_state <= S_VA;
                S_VA:    r_state <= S_START;
                S_START: r_state <= S_CINIT;
                S_CINIT: r_state <= S_RUN;
                S_RUN: begin
                    if (r_cnt == CORDIC_STEPS[CNT_W-1:0] && !w_lin_busy && !w_ang_busy) begin
                        r_state <= S_MX;
                    end
                end
                S_MX:    r_state <= S_MY;
                S_MY:    r_state <= S_UPD;
                S_UPD: begin
                    r_state <= S_DONE;
                    if (r_mean != '0) begin
                        if (w_x_sum > POS_HI) begin
                            r_x_acc <= POS_HI[POS_W-1:0];
                        end else if (w_x_sum < POS_LO) begin
                            r_x_acc <= POS_LO[POS_W-1:0];
                        end else begin
                            r_x_acc <= w_x_sum[POS_W-1:0];
                        end
                        if (w_y_sum > POS_HI) begin
                            r_y_acc <= POS_HI[POS_W-1:0];
                        end else if (w_y_sum < POS_LO) begin
                            r_y_acc <= POS_LO[POS_W-1:0];
                        end else begin
                            r_y_acc <= w_y_sum[POS_W-1:0];
                        end
                    end
                    r_heading <= r_heading + r_dbau;
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                r_dl <= i_pop_data.dl;
                r_dr <= i_pop_data.dr;
                r_dt <= i_pop_data.dt;
            end
            S_HEAD: begin
                r_mean  <= w_sum[32:1];
                r_prodw <= w_prodw[56:0];
            end
            S_K0: r_p0 <= w_a49[23:0] * RAD_TO_BAU;
            S_K1: r_p1 <= w_p1_full[24:0];
            S_VL: r_lin_num <= w_lin_full[51:0];
            S_VA: r_ang_num <= w_ang_full[60:0];
            S_START: begin
                r_dbau <= w_kprod[47:16];
                r_half <= w_kprod[48:17];
            end
            S_CINIT: begin
                r_cx  <= CORDIC_GAIN;
                r_cy  <= '0;
                r_cnt <= '0;
                if (w_z0 > QUARTER_TURN) begin
                    r_cz   <= w_z0 - HALF_TURN;
                    r_flip <= 1'b1;
                end else if (w_z0 < -QUARTER_TURN) begin
                    r_cz   <= w_z0 + HALF_TURN;
                    r_flip <= 1'b1;
                end else begin
                    r_cz   <= w_z0;
                    r_flip <= 1'b0;
                end
            end
            S_RUN: begin
                if (r_cnt != CORDIC_STEPS[CNT_W-1:0]) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (!r_cz[CORDIC_W-1]) begin
                        r_cx <= r_cx - w_ys;
                        r_cy <= r_cy + w_xs;
                        r_cz <= r_cz - atan_bau(r_cnt);
                    end else begin
                        r_cx <= r_cx + w_ys;
                        r_cy <= r_cy - w_xs;
                        r_cz <= r_cz + atan_bau(r_cnt);
                    end
                end
            end
            S_MX: r_px <= w_mx[65:30];
            S_MY: r_py <= w_my[65:30];
            default: ;
        endcase

        if (w_load) begin
            o_x_position     <= w_x_ext[OUT_POS_W-1:0];
            o_y_position     <= w_y_ext[OUT_POS_W-1:0];
            o_heading        <= r_heading;
            o_velocity_valid <= (r_dt != '0);
            if (r_dt != '0) begin
                o_linear_velocity  <= w_lin_q;
                o_angular_velocity <= w_ang_q;
            end else begin
                o_linear_velocity  <= '0;
                o_angular_velocity <= '0;
            end
        end
    end

endmodule

// ----- tb/sv/odometry_checker.sv -----
// ----------------------------------------------------------------------------
// Odometry result checker
// Watches the sample and result channels, predicts pose and velocities for
// every accepted sample and compares each result field by field.
// ----------------------------------------------------------------------------
module odometry_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_ready,
    input  logic signed [ddo_pkg::DIST_W-1:0]    i_left_distance,
    input  logic signed [ddo_pkg::DIST_W-1:0]    i_right_distance,
    input  logic        [ddo_pkg::TIME_W-1:0]    i_elapsed_time,
    input  logic                                 o_valid,
    input  logic                                 i_ready,
    input  logic signed [ddo_pkg::OUT_POS_W-1:0] o_x_position,
    input  logic signed [ddo_pkg::OUT_POS_W-1:0] o_y_position,
    input  logic        [ddo_pkg::HEAD_W-1:0]    o_heading,
    input  logic signed [ddo_pkg::VEL_W-1:0]     o_linear_velocity,
    input  logic signed [ddo_pkg::VEL_W-1:0]     o_angular_velocity,
    input  logic                                 o_velocity_valid,
    input  logic                                 i_cfg_we,
    input  logic        [ddo_pkg::TRACK_W-1:0]   i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import ddo_pkg::*;

    typedef struct packed {
        logic signed [OUT_POS_W-1:0] x;
        logic signed [OUT_POS_W-1:0] y;
        logic [HEAD_W-1:0]           hd;
        logic signed [VEL_W-1:0]     lin;
        logic signed [VEL_W-1:0]     ang;
        logic                        vv;
    } t_pose;

    localparam longint POS_HI = (64'sd1 <<< (POS_W - 1)) - 1;
    localparam longint POS_LO = -POS_HI - 1;

    const longint ATAN_TAB[30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1};

    t_pose       pose_q[$];
    logic [23:0] track_w;
    logic        seeded;
    logic [31:0] left_zero, right_zero, left_last, right_last;
    longint      x_acc, y_acc;
    logic [31:0] head_acc;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint pos_add(longint acc, longint d);
        if (d > 0 && acc > POS_HI - d) return POS_HI;
        if (d < 0 && acc < POS_LO - d) return POS_LO;
        return acc + d;
    endfunction

    task automatic rotate(input logic [31:0] angle, output longint c, output longint s);
        longint z, x, y, t, xs, ys;
        bit flip;
        z = longint'(signed'(angle));
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            flip = 1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            flip = 1;
        end
        for (int i = 0; i < 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                t = x - ys;
                y = y + xs;
                z -= ATAN_TAB[i];
            end else begin
                t = x + ys;
                y = y - xs;
                z += ATAN_TAB[i];
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic advance(input logic [31:0] l, input logic [31:0] r, input logic [23:0] dt);
        logic [31:0] rl, rr, dl32, dr32, half, dbau;
        longint dl, dr, mean, a, c, s, lin, ang;
        logic [63:0] prod;
        t_pose p;
        if (!seeded) begin
            left_zero  = l;
            right_zero = r;
            left_last  = 0;
            right_last = 0;
            seeded     = 1;
        end
        rl = l - left_zero;
        rr = r - right_zero;
        dl32 = rl - left_last;
        dr32 = rr - right_last;
        dl = longint'(signed'(dl32));
        dr = longint'(signed'(dr32));
        left_last  = rl;
        right_last = rr;
        mean = (dl + dr) >>> 1;
        a = ((dr - dl) * longint'({40'd0, track_w})) >>> 16;
        prod = a * 64'd683565276;
        dbau = prod[47:16];
        half = prod[48:17];
        if (mean != 0) begin
            rotate(head_acc + half, c, s);
            x_acc = pos_add(x_acc, (mean * c) >>> 30);
            y_acc = pos_add(y_acc, (mean * s) >>> 30);
        end
        head_acc = head_acc + dbau;
        lin = 0;
        ang = 0;
        if (dt != 0) begin
            lin = clip32(mean * 1000000 / longint'({40'd0, dt}));
            ang = clip32(a * 1000000 / longint'({40'd0, dt}));
        end
        p.x   = x_acc[OUT_POS_W-1:0];
        p.y   = y_acc[OUT_POS_W-1:0];
        p.hd  = head_acc;
        p.lin = lin[31:0];
        p.ang = ang[31:0];
        p.vv  = (dt != 0);
        pose_q.push_back(p);
    endtask

    task automatic compare(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pose e;
        if (!i_rst_n) begin
            track_w  = TRACK_RESET;
            seeded   = 0;
            left_zero = 0; right_zero = 0; left_last = 0; right_last = 0;
            x_acc = 0; y_acc = 0; head_acc = 0;
            pose_q.delete();
        end else begin
            if (i_cfg_we)
                track_w = i_cfg_data;
            if (i_valid && o_ready)
                advance(i_left_distance, i_right_distance, i_elapsed_time);
            if (o_valid && i_ready) begin
                o_results_seen++;
                if (pose_q.size() == 0) begin
                    $display("%0t mismatch: unexpected result, expected none actual x=%h",
                             $realtime, o_x_position);
                    o_fail_count++;
                end else begin
                    e = pose_q.pop_front();
                    compare("x_position", e.x, o_x_position);
                    compare("y_position", e.y, o_y_position);
                    compare("heading", e.hd, o_heading);
                    compare("linear_velocity", e.lin, o_linear_velocity);
                    compare("angular_velocity", e.ang, o_angular_velocity);
                    compare("velocity_valid", e.vv, o_velocity_valid);
                end
            end
        end
        o_pending <= pose_q.size();
    end

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_results_seen = 0;
    end
endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Odometry testbench top
// Drives wheel distance samples and track width settings with random gaps
// and receiver stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ddo_pkg::*;

    localparam int WATCHDOG = 5000;

    logic                        i_clk, i_rst_n;
    logic                        i_valid, o_ready, o_valid, i_ready;
    logic signed [DIST_W-1:0]    i_left_distance, i_right_distance;
    logic        [TIME_W-1:0]    i_elapsed_time;
    logic signed [OUT_POS_W-1:0] o_x_position, o_y_position;
    logic        [HEAD_W-1:0]    o_heading;
    logic signed [VEL_W-1:0]     o_linear_velocity, o_angular_velocity;
    logic                        o_velocity_valid;
    logic                        i_cfg_we;
    logic        [TRACK_W-1:0]   i_cfg_data;
    int fail_count, pending, results_seen;

    bit          no_gaps, long_hold;
    int          quiet_cycles, sent;
    logic [31:0] wheel_l, wheel_r;

    differential_drive_odometry DUT (.*);

    odometry_checker u_checker (
        .*,
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results_seen(results_seen)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random hold-off per result, one long stall on request
    initial begin
        int hold;
        i_ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_ready <= 0;
                repeat (400) @(posedge i_clk);
                long_hold = 0;
            end
            hold = no_gaps ? 0 : $urandom_range(0, 14);
            if (hold > 0) begin
                i_ready <= 0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1;
            forever begin
                @(negedge i_clk);
                if (o_valid) break;
            end
            @(posedge i_clk);
        end
    end

    task automatic send(input logic [31:0] l, input logic [31:0] r, input logic [23:0] dt);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1;
        i_left_distance  <= l;
        i_right_distance <= r;
        i_elapsed_time   <= dt;
        forever begin
            @(negedge i_clk);
            if (o_ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        if (!no_gaps)
            i_valid <= 0;
        wheel_l = l;
        wheel_r = r;
        sent++;
    endtask

    task automatic set_track(input logic [23:0] v);
        i_valid <= 0;
        wait (pending == 0);
        repeat (60) @(posedge i_clk);
        i_cfg_we   <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 0;
    endtask

    function automatic logic [23:0] pick_dt();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 24'($urandom_range(1, 20));
            2, 3:    return 24'($urandom);
            default: return 24'($urandom_range(500, 20000));
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [31:0] l, r, step;
        for (int k = 0; k < count; k++) begin
            if (($urandom_range(0, 99) == 0))
                no_gaps = ~no_gaps;
            case ($urandom_range(0, 19))
                0: begin
                    l = $urandom;
                    r = $urandom;
                end
                1: begin
                    l = wheel_l + $urandom;
                    r = wheel_r + $urandom;
                end
                2: begin
                    step = $urandom_range(0, 65536 * 4);
                    l = wheel_l - step;
                    r = wheel_r + step;
                end
                default: begin
                    step = $urandom_range(0, 65536 / 4);
                    l = wheel_l + step + $urandom_range(0, 4096) - 2048;
                    r = wheel_r + step + $urandom_range(0, 4096) - 2048;
                    if ($urandom_range(0, 3) == 0) begin
                        l = wheel_l - step;
                        r = wheel_r - step - $urandom_range(0, 2048);
                    end
                end
            endcase
            send(l, r, pick_dt());
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_cfg_we = 0;
        i_cfg_data = '0;
        i_left_distance = '0;
        i_right_distance = '0;
        i_elapsed_time = '0;
        no_gaps = 0;
        long_hold = 0;
        sent = 0;
        wheel_l = 0;
        wheel_r = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: first sample at the extremes, wraps, spins, zero and tiny time
        send(32'h8000_0000, 32'h7fff_ffff, 24'hff_ffff);
        send(32'h8000_0000, 32'h7fff_ffff, 24'd0);
        send(32'h8000_1000, 32'h8000_1000, 24'd1000);
        send(32'hffff_ffff, 32'h0000_0000, 24'd1);
        send(32'h7fff_ffff, 32'h8000_0000, 24'd1);
        send(32'h0000_0000, 32'hffff_ffff, 24'hff_ffff);
        send(32'h0001_0000, 32'hfffe_0000, 24'd5000);
        send(32'h0002_0000, 32'hffff_0000, 24'd0);
        send(32'h0002_0000, 32'h0002_0000, 24'd1);
        send(32'h5555_5555, 32'haaaa_aaaa, 24'h55_5555);
        send(32'haaaa_aaaa, 32'h5555_5555, 24'haa_aaaa);
        send(32'haaaa_bbbb, 32'h5555_6666, 24'd1000);

        set_track(24'hff_ffff);
        send(wheel_l + 32'h0001_0000, wheel_r - 32'h0001_0000, 24'd1000);
        send(wheel_l - 32'h7fff_ffff, wheel_r + 32'h7fff_ffff, 24'd1);
        send(wheel_l, wheel_r + 1, 24'd2);
        random_phase(340);

        set_track(24'd0);
        send(wheel_l + 32'h0003_0000, wheel_r - 32'h0001_0000, 24'd1000);
        send(wheel_l, wheel_r, 24'd0);
        fork
            random_phase(360);
            begin
                repeat (200) @(posedge i_clk);
                long_hold = 1;
            end
        join

        set_track(24'd1);
        random_phase(360);

        set_track(TRACK_RESET);
        no_gaps = 1;
        random_phase(120);
        no_gaps = 0;
        random_phase(240);

        set_track(24'($urandom_range(1, 24'hff_ffff)));
        random_phase(360);

        i_valid <= 0;
        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        $display("%0d samples sent, %0d results checked across six track width settings",
                 sent, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
